/* design/ddpi_pkg.sv */
// ----------------------------------------------------------------------------
// ddpi_pkg
// Shared constants, codes, types and helper functions of the differential
// drive pose integrator.
// ----------------------------------------------------------------------------
package ddpi_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int POS_FRAC_DEF     = 16;

  localparam int ANG_W   = 34;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DNUM_W  = 64;
  localparam int DDEN_W  = 40;
  localparam int ATAN_N  = 30;

  localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [ANG_W-1:0] GAIN_Q30    = 34'sd652032874;

  localparam logic [1:0] ACT_SET_VEL = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_START   = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic [2:0] REG_MAX_LIN   = 3'd0;
  localparam logic [2:0] REG_MAX_TURN  = 3'd1;
  localparam logic [2:0] REG_STEP_TIME = 3'd2;
  localparam logic [2:0] REG_START_X   = 3'd3;
  localparam logic [2:0] REG_START_Y   = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TH_GO,
    ST_TH_WAIT,
    ST_REDUCE,
    ST_SC1_GO,
    ST_SC1_WAIT,
    ST_SC2_GO,
    ST_SC2_WAIT,
    ST_ARC_MUL_GO,
    ST_ARC_MUL_WAIT,
    ST_ARC_DIV_GO,
    ST_ARC_DIV_WAIT,
    ST_LIN_GO,
    ST_LIN_WAIT,
    ST_PROJ_GO,
    ST_PROJ_WAIT,
    ST_UPDATE,
    ST_DONE
  } seq_state_t;

  function automatic logic [31:0] atan_q28(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'd210828714;
      5'd1:  val = 32'd124459457;
      5'd2:  val = 32'd65760959;
      5'd3:  val = 32'd33381290;
      5'd4:  val = 32'd16755422;
      5'd5:  val = 32'd8385879;
      5'd6:  val = 32'd4193963;
      5'd7:  val = 32'd2097109;
      5'd8:  val = 32'd1048571;
      5'd9:  val = 32'd524287;
      5'd10: val = 32'd262144;
      5'd11: val = 32'd131072;
      5'd12: val = 32'd65536;
      5'd13: val = 32'd32768;
      5'd14: val = 32'd16384;
      5'd15: val = 32'd8192;
      5'd16: val = 32'd4096;
      5'd17: val = 32'd2048;
      5'd18: val = 32'd1024;
      5'd19: val = 32'd512;
      5'd20: val = 32'd256;
      5'd21: val = 32'd128;
      5'd22: val = 32'd64;
      5'd23: val = 32'd32;
      5'd24: val = 32'd16;
      5'd25: val = 32'd8;
      5'd26: val = 32'd4;
      5'd27: val = 32'd2;
      5'd28: val = 32'd1;
      5'd29: val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

  function automatic logic signed [15:0] clamp_vel(input logic signed [15:0] cmd,
                                                   input logic [14:0] lim);
    logic signed [16:0] c;
    logic signed [16:0] hi;
    logic signed [16:0] r;
    c  = 17'(cmd);
    hi = $signed({2'b00, lim});
    r  = c;
    if (c > hi) begin
      r = hi;
    end
    if (c < -hi) begin
      r = -hi;
    end
    return r[15:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                 input logic signed [63:0] d);
    logic signed [64:0] s;
    logic signed [31:0] r;
    s = 65'(p) + 65'(d);
    if (s > 65'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (s < -65'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

/* design/ddpi_serial_mul.sv */
// ----------------------------------------------------------------------------
// ddpi_serial_mul
// Unsigned shift-and-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddpi_serial_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ddpi_pkg::MUL_W-1:0]   a,
  input  logic [ddpi_pkg::MUL_W-1:0]   b,
  output logic                         done,
  output logic [ddpi_pkg::PROD_W-1:0]  prod
);

  localparam int W     = ddpi_pkg::MUL_W;
  localparam int CNT_W = $clog2(W);

  logic             active_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     a_r;
  logic [W-1:0]     b_r;
  logic [2*W-1:0]   acc_r;
  logic [W:0]       sum;

  assign sum  = {1'b0, acc_r[2*W-1:W]} + (b_r[0] ? {1'b0, a_r} : {(W+1){1'b0}});
  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (active_r) begin
      acc_r <= {sum, acc_r[W-1:1]};
      b_r   <= {1'b0, b_r[W-1:1]};
    end
  end

endmodule

/* design/ddpi_serial_div.sv */
// ----------------------------------------------------------------------------
// ddpi_serial_div
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddpi_serial_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ddpi_pkg::DNUM_W-1:0]  num,
  input  logic [ddpi_pkg::DDEN_W-1:0]  den,
  output logic                         done,
  output logic [ddpi_pkg::DNUM_W-1:0]  quot
);

  localparam int NW    = ddpi_pkg::DNUM_W;
  localparam int DW    = ddpi_pkg::DDEN_W;
  localparam int CNT_W = $clog2(NW);

  logic             active_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW-1:0]    q_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;
  logic             ge;

  assign shifted = {rem_r, q_r[NW-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};
  assign done    = done_r;
  assign quot    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NW - 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (active_r) begin
      rem_r <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

endmodule

/* design/ddpi_cordic.sv */
// ----------------------------------------------------------------------------
// ddpi_cordic
// Rotation-mode CORDIC with quadrant folding, one iteration per cycle.
// ----------------------------------------------------------------------------
module ddpi_cordic #(
  parameter int STEPS = ddpi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [31:0]                 angle,
  output logic                               done,
  output logic signed [ddpi_pkg::ANG_W-1:0]  sin_o,
  output logic signed [ddpi_pkg::ANG_W-1:0]  cos_o
);

  localparam int AW    = ddpi_pkg::ANG_W;
  localparam int CNT_W = $clog2(STEPS + 2);

  logic                 active_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 neg_r;
  logic signed [AW-1:0] x_r;
  logic signed [AW-1:0] y_r;
  logic signed [AW-1:0] z_r;
  logic [4:0]           idx;
  logic signed [AW-1:0] xs;
  logic signed [AW-1:0] ys;
  logic signed [AW-1:0] at;

  assign idx   = 5'(cnt_r - CNT_W'(2));
  assign xs    = x_r >>> idx;
  assign ys    = y_r >>> idx;
  assign at    = $signed({2'b00, ddpi_pkg::atan_q28(idx)});
  assign done  = done_r;
  assign sin_o = neg_r ? -y_r : y_r;
  assign cos_o = neg_r ? -x_r : x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS + 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      z_r   <= AW'(angle);
      neg_r <= 1'b0;
    end else if (active_r) begin
      if (cnt_r == CNT_W'(0)) begin
        if (z_r > ddpi_pkg::PI_Q28) begin
          z_r <= z_r - ddpi_pkg::TWO_PI_Q28;
        end else if (z_r < -ddpi_pkg::PI_Q28) begin
          z_r <= z_r + ddpi_pkg::TWO_PI_Q28;
        end
      end else if (cnt_r == CNT_W'(1)) begin
        x_r <= ddpi_pkg::GAIN_Q30;
        y_r <= '0;
        if (z_r > ddpi_pkg::HALF_PI_Q28) begin
          z_r   <= z_r - ddpi_pkg::PI_Q28;
          neg_r <= 1'b1;
        end else if (z_r < -ddpi_pkg::HALF_PI_Q28) begin
          z_r   <= z_r + ddpi_pkg::PI_Q28;
          neg_r <= 1'b1;
        end
      end else if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

endmodule

/* design/diff_drive_pose_integrator_core.sv */
// ----------------------------------------------------------------------------
// diff_drive_pose_integrator_core
// Dead-reckoning pose integrator for a differential-drive robot using the
// exact arc, with serial multiplier, divider and CORDIC units.
//
//   Channel  Direction  Handshake            Payload
//   in       request    in_valid/in_stall    action, linear and angular command
//   out      result     out_valid/out_stall  x, y, heading, speeds
//   cfg      write/read psel/penable/pready  five registers at 4*index
//
// A velocity, start or unknown request goes from idle straight to the done
// state. A tick runs the heading multiply, wrap reduction and a CORDIC run on
// the old heading; an arc adds a CORDIC run on the new heading and a multiply
// and a divide per axis, a straight step a distance multiply and a multiply
// per axis. One request is in work at a time; the result waits in an
// output register while out_stall is high. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module diff_drive_pose_integrator_core #(
  parameter int CORDIC_STEPS       = ddpi_pkg::CORDIC_STEPS_DEF,
  parameter int POSITION_FRAC_BITS = ddpi_pkg::POS_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [15:0] in_linear_command,
  input  logic signed [15:0] in_angular_command,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x_out,
  output logic signed [31:0] out_pos_y_out,
  output logic signed [31:0] out_heading_out,
  output logic signed [15:0] out_linear_speed_out,
  output logic signed [15:0] out_turn_rate_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW         = ddpi_pkg::ANG_W;
  localparam int MW         = ddpi_pkg::MUL_W;
  localparam int PW         = ddpi_pkg::PROD_W;
  localparam int NW         = ddpi_pkg::DNUM_W;
  localparam int DW         = ddpi_pkg::DDEN_W;
  localparam int DEN_SHIFT  = 30 - POSITION_FRAC_BITS;
  localparam int PROJ_SHIFT = 54 - POSITION_FRAC_BITS;

  ddpi_pkg::seq_state_t state_r, state_nxt;

  logic [14:0]        max_lin_r;
  logic [14:0]        max_turn_r;
  logic [19:0]        step_time_r;
  logic signed [31:0] start_x_r;
  logic signed [31:0] start_y_r;

  logic signed [31:0] pos_x_r;
  logic signed [31:0] pos_y_r;
  logic signed [31:0] heading_r;
  logic signed [15:0] lin_r;
  logic signed [15:0] turn_r;

  logic signed [AW-1:0] h2_r;
  logic signed [AW-1:0] s1_r;
  logic signed [AW-1:0] c1_r;
  logic signed [AW:0]   ds_r;
  logic signed [AW:0]   dc_r;
  logic [MW-1:0]        d24_mag_r;
  logic                 d24_neg_r;
  logic                 sign_r;
  logic                 axis_r;
  logic signed [63:0]   dx_r;
  logic signed [63:0]   dy_r;

  logic               out_valid_r;
  logic signed [31:0] out_x_r;
  logic signed [31:0] out_y_r;
  logic signed [31:0] out_h_r;
  logic signed [15:0] out_v_r;
  logic signed [15:0] out_w_r;

  logic           mul_start;
  logic [MW-1:0]  mul_a;
  logic [MW-1:0]  mul_b;
  logic           mul_done;
  logic [PW-1:0]  mul_prod;
  logic           div_start;
  logic [NW-1:0]  div_num;
  logic [DW-1:0]  div_den;
  logic           div_done;
  logic [NW-1:0]  div_quot;
  logic           cor_start;
  logic signed [31:0]   cor_angle;
  logic                 cor_done;
  logic signed [AW-1:0] cor_sin;
  logic signed [AW-1:0] cor_cos;

  logic               accept;
  logic               cfg_write;
  logic               out_free;
  logic [15:0]        v_mag;
  logic [15:0]        w_mag;
  logic [AW:0]        ds_mag;
  logic [AW:0]        dc_mag;
  logic [AW-1:0]      s1_mag;
  logic [AW-1:0]      c1_mag;
  logic [35:0]        th_round;
  logic [35:0]        lin_round;
  logic signed [AW-1:0] dth;
  logic [PW-1:0]      proj_round;
  logic [PW-1:0]      proj_mag;
  logic signed [63:0] proj_delta;
  logic signed [63:0] arc_delta;

  assign accept    = (state_r == ddpi_pkg::ST_IDLE) && in_valid;
  assign in_stall  = state_r != ddpi_pkg::ST_IDLE;
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign v_mag  = lin_r[15] ? 16'(-lin_r) : 16'(lin_r);
  assign w_mag  = turn_r[15] ? 16'(-turn_r) : 16'(turn_r);
  assign ds_mag = ds_r[AW] ? (AW+1)'(-ds_r) : (AW+1)'(ds_r);
  assign dc_mag = dc_r[AW] ? (AW+1)'(-dc_r) : (AW+1)'(dc_r);
  assign s1_mag = s1_r[AW-1] ? AW'(-s1_r) : AW'(s1_r);
  assign c1_mag = c1_r[AW-1] ? AW'(-c1_r) : AW'(c1_r);

  assign th_round   = mul_prod[35:0] + 36'd8;
  assign dth        = turn_r[15] ? -$signed({2'b00, th_round[35:4]})
                                 : $signed({2'b00, th_round[35:4]});
  assign lin_round  = mul_prod[35:0] + 36'd128;
  assign proj_round = mul_prod + (PW'(1) << (PROJ_SHIFT - 1));
  assign proj_mag   = proj_round >> PROJ_SHIFT;
  assign proj_delta = sign_r ? -$signed(proj_mag) : $signed(proj_mag);
  assign arc_delta  = sign_r ? -$signed(div_quot) : $signed(div_quot);
  assign div_den    = DW'(w_mag) << DEN_SHIFT;

  ddpi_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ddpi_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  ddpi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .sin_o (cor_sin),
    .cos_o (cor_cos)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ddpi_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_action == ddpi_pkg::ACT_TICK) ? ddpi_pkg::ST_TH_GO
                                                        : ddpi_pkg::ST_DONE;
        end
      end
      ddpi_pkg::ST_TH_GO: state_nxt = ddpi_pkg::ST_TH_WAIT;
      ddpi_pkg::ST_TH_WAIT: begin
        if (mul_done) begin
          state_nxt = ddpi_pkg::ST_REDUCE;
        end
      end
      ddpi_pkg::ST_REDUCE: begin
        if (h2_r < ddpi_pkg::TWO_PI_Q28 && h2_r > -ddpi_pkg::TWO_PI_Q28) begin
          state_nxt = ddpi_pkg::ST_SC1_GO;
        end
      end
      ddpi_pkg::ST_SC1_GO: state_nxt = ddpi_pkg::ST_SC1_WAIT;
      ddpi_pkg::ST_SC1_WAIT: begin
        if (cor_done) begin
          state_nxt = (turn_r != 16'sd0) ? ddpi_pkg::ST_SC2_GO : ddpi_pkg::ST_LIN_GO;
        end
      end
      ddpi_pkg::ST_SC2_GO: state_nxt = ddpi_pkg::ST_SC2_WAIT;
      ddpi_pkg::ST_SC2_WAIT: begin
        if (cor_done) begin
          state_nxt = ddpi_pkg::ST_ARC_MUL_GO;
        end
      end
      ddpi_pkg::ST_ARC_MUL_GO: state_nxt = ddpi_pkg::ST_ARC_MUL_WAIT;
      ddpi_pkg::ST_ARC_MUL_WAIT: begin
        if (mul_done) begin
          state_nxt = ddpi_pkg::ST_ARC_DIV_GO;
        end
      end
      ddpi_pkg::ST_ARC_DIV_GO: state_nxt = ddpi_pkg::ST_ARC_DIV_WAIT;
      ddpi_pkg::ST_ARC_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = axis_r ? ddpi_pkg::ST_UPDATE : ddpi_pkg::ST_ARC_MUL_GO;
        end
      end
      ddpi_pkg::ST_LIN_GO: state_nxt = ddpi_pkg::ST_LIN_WAIT;
      ddpi_pkg::ST_LIN_WAIT: begin
        if (mul_done) begin
          state_nxt = ddpi_pkg::ST_PROJ_GO;
        end
      end
      ddpi_pkg::ST_PROJ_GO: state_nxt = ddpi_pkg::ST_PROJ_WAIT;
      ddpi_pkg::ST_PROJ_WAIT: begin
        if (mul_done) begin
          state_nxt = axis_r ? ddpi_pkg::ST_UPDATE : ddpi_pkg::ST_PROJ_GO;
        end
      end
      ddpi_pkg::ST_UPDATE: state_nxt = ddpi_pkg::ST_DONE;
      ddpi_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ddpi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ddpi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    cor_start = 1'b0;
    cor_angle = '0;
    case (state_r)
      ddpi_pkg::ST_TH_GO: begin
        mul_start = 1'b1;
        mul_a     = MW'(w_mag);
        mul_b     = MW'(step_time_r);
      end
      ddpi_pkg::ST_SC1_GO: begin
        cor_start = 1'b1;
        cor_angle = heading_r;
      end
      ddpi_pkg::ST_SC2_GO: begin
        cor_start = 1'b1;
        cor_angle = h2_r[31:0];
      end
      ddpi_pkg::ST_ARC_MUL_GO: begin
        mul_start = 1'b1;
        mul_a     = MW'(v_mag);
        mul_b     = axis_r ? dc_mag[MW-1:0] : ds_mag[MW-1:0];
      end
      ddpi_pkg::ST_ARC_DIV_GO: begin
        div_start = 1'b1;
        div_num   = NW'(mul_prod) + NW'(div_den[DW-1:1]);
      end
      ddpi_pkg::ST_LIN_GO: begin
        mul_start = 1'b1;
        mul_a     = MW'(v_mag);
        mul_b     = MW'(step_time_r);
      end
      ddpi_pkg::ST_PROJ_GO: begin
        mul_start = 1'b1;
        mul_a     = d24_mag_r;
        mul_b     = axis_r ? s1_mag[MW-1:0] : c1_mag[MW-1:0];
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (paddr[4:2])
      ddpi_pkg::REG_MAX_LIN:   prdata = 32'(max_lin_r);
      ddpi_pkg::REG_MAX_TURN:  prdata = 32'(max_turn_r);
      ddpi_pkg::REG_STEP_TIME: prdata = 32'(step_time_r);
      ddpi_pkg::REG_START_X:   prdata = start_x_r;
      ddpi_pkg::REG_START_Y:   prdata = start_y_r;
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ddpi_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      max_lin_r   <= 15'd4096;
      max_turn_r  <= 15'd12868;
      step_time_r <= 20'd20972;
      start_x_r   <= '0;
      start_y_r   <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      lin_r       <= '0;
      turn_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ddpi_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_write) begin
        case (paddr[4:2])
          ddpi_pkg::REG_MAX_LIN:   max_lin_r   <= pwdata[14:0];
          ddpi_pkg::REG_MAX_TURN:  max_turn_r  <= pwdata[14:0];
          ddpi_pkg::REG_STEP_TIME: step_time_r <= pwdata[19:0];
          ddpi_pkg::REG_START_X:   start_x_r   <= pwdata;
          ddpi_pkg::REG_START_Y:   start_y_r   <= pwdata;
          default: begin
          end
        endcase
      end
      if (accept) begin
        case (in_action)
          ddpi_pkg::ACT_SET_VEL: begin
            lin_r  <= ddpi_pkg::clamp_vel(in_linear_command, max_lin_r);
            turn_r <= ddpi_pkg::clamp_vel(in_angular_command, max_turn_r);
          end
          ddpi_pkg::ACT_START: begin
            pos_x_r   <= start_x_r;
            pos_y_r   <= start_y_r;
            heading_r <= '0;
          end
          default: begin
          end
        endcase
      end
      if (state_r == ddpi_pkg::ST_UPDATE) begin
        pos_x_r   <= ddpi_pkg::sat_add(pos_x_r, dx_r);
        pos_y_r   <= ddpi_pkg::sat_add(pos_y_r, dy_r);
        heading_r <= h2_r[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ddpi_pkg::ST_TH_WAIT: begin
        if (mul_done) begin
          h2_r <= AW'(heading_r) + dth;
        end
      end
      ddpi_pkg::ST_REDUCE: begin
        if (h2_r >= ddpi_pkg::TWO_PI_Q28) begin
          h2_r <= h2_r - ddpi_pkg::TWO_PI_Q28;
        end else if (h2_r <= -ddpi_pkg::TWO_PI_Q28) begin
          h2_r <= h2_r + ddpi_pkg::TWO_PI_Q28;
        end
      end
      ddpi_pkg::ST_SC1_WAIT: begin
        if (cor_done) begin
          s1_r   <= cor_sin;
          c1_r   <= cor_cos;
          axis_r <= 1'b0;
        end
      end
      ddpi_pkg::ST_SC2_WAIT: begin
        if (cor_done) begin
          ds_r <= (AW+1)'(cor_sin) - (AW+1)'(s1_r);
          dc_r <= (AW+1)'(c1_r) - (AW+1)'(cor_cos);
        end
      end
      ddpi_pkg::ST_ARC_MUL_GO: begin
        sign_r <= lin_r[15] ^ turn_r[15] ^ (axis_r ? dc_r[AW] : ds_r[AW]);
      end
      ddpi_pkg::ST_ARC_DIV_WAIT: begin
        if (div_done) begin
          if (axis_r) begin
            dy_r <= arc_delta;
          end else begin
            dx_r <= arc_delta;
          end
          axis_r <= 1'b1;
        end
      end
      ddpi_pkg::ST_LIN_WAIT: begin
        if (mul_done) begin
          d24_mag_r <= MW'(lin_round[35:8]);
          d24_neg_r <= lin_r[15];
        end
      end
      ddpi_pkg::ST_PROJ_GO: begin
        sign_r <= d24_neg_r ^ (axis_r ? s1_r[AW-1] : c1_r[AW-1]);
      end
      ddpi_pkg::ST_PROJ_WAIT: begin
        if (mul_done) begin
          if (axis_r) begin
            dy_r <= proj_delta;
          end else begin
            dx_r <= proj_delta;
          end
          axis_r <= 1'b1;
        end
      end
      ddpi_pkg::ST_DONE: begin
        if (out_free) begin
          out_x_r <= pos_x_r;
          out_y_r <= pos_y_r;
          out_h_r <= heading_r;
          out_v_r <= lin_r;
          out_w_r <= turn_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_pos_x_out        = out_x_r;
  assign out_pos_y_out        = out_y_r;
  assign out_heading_out      = out_h_r;
  assign out_linear_speed_out = out_v_r;
  assign out_turn_rate_out    = out_w_r;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the differential drive pose integrator. Requests
// with random content and random gaps go in, every result is compared with a
// bit-exact pose predictor, and the limit, step and start registers are
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
class pose_scoreboard;
  logic [31:0] max_lin, max_turn, dt;
  logic signed [31:0] sx, sy;
  logic signed [31:0] px, py, hd;
  logic signed [15:0] vl, wr;
  logic [127:0] pending[$];
  int errors;

  function new();
    max_lin = 4096; max_turn = 12868; dt = 20972; sx = 0; sy = 0;
    px = 0; py = 0; hd = 0; vl = 0; wr = 0; errors = 0;
  endfunction

  function longint rnd_div(longint n, longint d);
    bit neg;
    longint un, ud, q;
    neg = (n < 0) != (d < 0);
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = (un + ud / 2) / ud;
    return neg ? -q : q;
  endfunction

  function longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function void sincos(longint a, output longint s, output longint c);
    longint atab[30] = '{210828714, 124459457, 65760959, 33381290, 16755422,
      8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 1};
    longint x, y, xs, ys;
    bit neg;
    x = 652032874; y = 0; neg = 0;
    a = a % 64'sd1686629713;
    if (a > 843314857) a -= 1686629713;
    if (a < -843314857) a += 1686629713;
    if (a > 421657428) begin a -= 843314857; neg = 1; end
    else if (a < -421657428) begin a += 843314857; neg = 1; end
    for (int i = 0; i < 24; i++) begin
      xs = fshr(x, i); ys = fshr(y, i);
      if (a >= 0) begin x -= ys; y += xs; a -= atab[i]; end
      else begin x += ys; y -= xs; a += atab[i]; end
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endfunction

  function logic signed [31:0] sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function logic signed [15:0] clampv(longint v, longint lim);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  function void advance();
    longint v, w, h2, dth, s1, c1, s2, c2, dx, dy, d24;
    v = vl; w = wr;
    dth = rnd_div(w * longint'(dt), 16);
    h2 = longint'(hd) + dth;
    sincos(hd, s1, c1);
    if (w != 0) begin
      sincos(h2, s2, c2);
      dx = rnd_div(v * (s2 - s1), w * 16384);
      dy = rnd_div(v * (c1 - c2), w * 16384);
    end else begin
      d24 = rnd_div(v * longint'(dt), 256);
      dx = rnd_div(d24 * c1, 64'sd1 << 38);
      dy = rnd_div(d24 * s1, 64'sd1 << 38);
    end
    px = sat(longint'(px) + dx);
    py = sat(longint'(py) + dy);
    h2 = h2 % 64'sd1686629713;
    hd = h2[31:0];
  endfunction

  function void note_request(logic [1:0] act, logic signed [15:0] lc,
                             logic signed [15:0] ac);
    if (act == ddpi_pkg::ACT_SET_VEL) begin
      vl = clampv(lc, max_lin); wr = clampv(ac, max_turn);
    end else if (act == ddpi_pkg::ACT_TICK) begin
      advance();
    end else if (act == ddpi_pkg::ACT_START) begin
      px = sx; py = sy; hd = 0;
    end
    pending.push_back({px, py, hd, vl, wr});
  endfunction

  function void check_result(logic [127:0] got);
    logic [127:0] exp;
    if (pending.size() == 0) begin
      $display("%0t unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got[127:96] !== exp[127:96])
      $display("%0t x expected %h actual %h", $time, exp[127:96], got[127:96]);
    if (got[95:64] !== exp[95:64])
      $display("%0t y expected %h actual %h", $time, exp[95:64], got[95:64]);
    if (got[63:32] !== exp[63:32])
      $display("%0t heading expected %h actual %h", $time, exp[63:32], got[63:32]);
    if (got[31:16] !== exp[31:16])
      $display("%0t linear expected %h actual %h", $time, exp[31:16], got[31:16]);
    if (got[15:0] !== exp[15:0])
      $display("%0t turn expected %h actual %h", $time, exp[15:0], got[15:0]);
    if (got !== exp) errors++;
  endfunction
endclass

module tb_top;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] in_action;
  logic signed [15:0] in_linear_command, in_angular_command;
  logic signed [31:0] out_pos_x_out, out_pos_y_out, out_heading_out;
  logic signed [15:0] out_linear_speed_out, out_turn_rate_out;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  pose_scoreboard pose_sb;
  bit hold_long;
  int unsigned cycles;

  diff_drive_pose_integrator_core i_dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 10000000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 400);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      pose_sb.check_result({out_pos_x_out, out_pos_y_out, out_heading_out,
                            out_linear_speed_out, out_turn_rate_out});
  end

  initial begin
    int g;
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1;
        repeat (3000) @(posedge clk);
        hold_long = 0;
      end
      g = gap_len();
      out_stall <= g > 0;
      repeat (g > 0 ? g : 1) @(posedge clk);
      out_stall <= 0;
      @(posedge clk);
    end
  end

  task write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
    case (idx)
      ddpi_pkg::REG_MAX_LIN: pose_sb.max_lin = val[14:0];
      ddpi_pkg::REG_MAX_TURN: pose_sb.max_turn = val[14:0];
      ddpi_pkg::REG_STEP_TIME: pose_sb.dt = val[19:0];
      ddpi_pkg::REG_START_X: pose_sb.sx = val;
      default: pose_sb.sy = val;
    endcase
  endtask

  task send(logic [1:0] act, logic [15:0] lc, logic [15:0] ac);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1; in_action <= act;
    in_linear_command <= lc; in_angular_command <= ac;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pose_sb.note_request(act, lc, ac);
  endtask

  task settle();
    in_valid <= 0;
    while (pose_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task random_phase(int n);
    logic [1:0] a;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: a = ddpi_pkg::ACT_SET_VEL;
        9: a = $urandom_range(0, 1) ? ddpi_pkg::ACT_START : ddpi_pkg::ACT_NONE;
        default: a = ddpi_pkg::ACT_TICK;
      endcase
      send(a, $urandom, $urandom);
    end
  endtask

  initial begin
    pose_sb = new();
    rst_n = 0; in_valid = 0; in_action = 0; in_linear_command = 0;
    in_angular_command = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0;
    pwdata = 0; hold_long = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(ddpi_pkg::ACT_TICK, 0, 0);
    send(ddpi_pkg::ACT_SET_VEL, 16'sh7fff, 16'sh7fff);
    send(ddpi_pkg::ACT_TICK, 0, 0);
    send(ddpi_pkg::ACT_SET_VEL, 16'sh8000, 16'sh8000);
    send(ddpi_pkg::ACT_TICK, 0, 0);
    send(ddpi_pkg::ACT_SET_VEL, 16'sd1000, 16'sd0);
    send(ddpi_pkg::ACT_TICK, 0, 0);
    send(ddpi_pkg::ACT_NONE, 16'sh1234, 16'sh4321);
    send(ddpi_pkg::ACT_START, 0, 0);
    settle();
    write_reg(ddpi_pkg::REG_MAX_LIN, 32'h7fff);
    write_reg(ddpi_pkg::REG_MAX_TURN, 32'h7fff);
    write_reg(ddpi_pkg::REG_STEP_TIME, 32'hfffff);
    write_reg(ddpi_pkg::REG_START_X, 32'h7fff0000);
    write_reg(ddpi_pkg::REG_START_Y, 32'h80010000);
    send(ddpi_pkg::ACT_START, 0, 0);
    send(ddpi_pkg::ACT_SET_VEL, 16'sh7fff, 16'sh0000);
    for (int i = 0; i < 4; i++) send(ddpi_pkg::ACT_TICK, 0, 0);
    send(ddpi_pkg::ACT_SET_VEL, 16'sh8000, 16'sh7fff);
    for (int i = 0; i < 4; i++) send(ddpi_pkg::ACT_TICK, 0, 0);
    hold_long = 1;
    random_phase(400);
    settle();
    write_reg(ddpi_pkg::REG_STEP_TIME, 32'h0);
    write_reg(ddpi_pkg::REG_MAX_LIN, 32'h0);
    write_reg(ddpi_pkg::REG_MAX_TURN, 32'h0);
    send(ddpi_pkg::ACT_SET_VEL, 16'sh7fff, 16'sh8000);
    random_phase(100);
    settle();
    write_reg(ddpi_pkg::REG_STEP_TIME, 32'd1);
    write_reg(ddpi_pkg::REG_MAX_LIN, $urandom_range(0, 32767));
    write_reg(ddpi_pkg::REG_MAX_TURN, $urandom_range(0, 32767));
    write_reg(ddpi_pkg::REG_START_X, $urandom);
    write_reg(ddpi_pkg::REG_START_Y, $urandom);
    random_phase(500);
    settle();
    write_reg(ddpi_pkg::REG_STEP_TIME, $urandom_range(1, 1048575));
    write_reg(ddpi_pkg::REG_MAX_LIN, 32'd4096);
    write_reg(ddpi_pkg::REG_MAX_TURN, 32'd12868);
    random_phase(500);
    settle();
    write_reg(ddpi_pkg::REG_STEP_TIME, 32'd20972);
    write_reg(ddpi_pkg::REG_START_X, 32'h0);
    write_reg(ddpi_pkg::REG_START_Y, 32'h0);
    random_phase(500);
    settle();
    repeat (50) @(posedge clk);
    if (pose_sb.errors == 0 && pose_sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
